@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, off while reset is high.
`define ASSERT_SYNC(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/pags_pkg.sv @@
// Types, constants and helper functions of the peak AGC gain stepper.
`default_nettype none

package pags_pkg;

  localparam int CHANNELS = 4;
  localparam int WINDOW   = 64;
  localparam int CNT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CH_W     = 2;
  localparam int PEND_W   = 3;
  localparam int GAIN_W   = 9;
  localparam int MAG_W    = 15;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_SET   = 1'b1;

  localparam logic [GAIN_W-1:0] GAIN_RESET     = 9'd210;
  localparam logic [MAG_W-1:0]  LOW_THR_RESET  = 15'd3276;
  localparam logic [MAG_W-1:0]  HIGH_THR_RESET = 15'd26213;
  localparam logic [GAIN_W-1:0] STEP_RESET     = 9'd30;
  localparam logic [GAIN_W-1:0] MAX_GAIN_RESET = 9'd480;

  localparam logic [3:0]  DAC_CMD_EVEN = 4'hB;
  localparam logic [3:0]  DAC_CMD_ODD  = 4'hF;
  localparam logic [11:0] DAC_CODE_HI  = 12'd1489;
  localparam logic [11:0] DAC_CODE_LO  = 12'd124;

  typedef enum logic [1:0] {
    REG_LOW_THR  = 2'd0,
    REG_HIGH_THR = 2'd1,
    REG_STEP     = 2'd2,
    REG_MAX_GAIN = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic               op;
    logic               burst_start;
    logic signed [15:0] sample_ch0;
    logic signed [15:0] sample_ch1;
    logic signed [15:0] sample_ch2;
    logic signed [15:0] sample_ch3;
    logic [2:0]         target_channel;
    logic [15:0]        requested_gain;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [GAIN_W-1:0] gain_tenths;
    logic [15:0]       dac_word;
    logic              chip_select;
    logic              last;
  } result_t;

  // Magnitude of a sample; the most negative code saturates.
  function automatic logic [MAG_W-1:0] abs_sat(input logic signed [15:0] s);
    logic [15:0] neg;
    neg = ~s + 16'd1;
    if (!s[15]) begin
      return s[MAG_W-1:0];
    end else if (neg[15]) begin
      return {MAG_W{1'b1}};
    end else begin
      return neg[MAG_W-1:0];
    end
  endfunction

  // Control voltage code for the gain amplifier.
  function automatic logic [11:0] vctl_code(input logic [GAIN_W-1:0] g);
    logic [11:0] code;
    if (g <= 9'd48) begin
      code = DAC_CODE_HI;
    end else if (g >= 9'd54) begin
      code = DAC_CODE_LO;
    end else begin
      case (g)
        9'd49:   code = 12'd1240;
        9'd50:   code = 12'd992;
        9'd51:   code = 12'd744;
        9'd52:   code = 12'd496;
        default: code = 12'd248;
      endcase
    end
    return code;
  endfunction

  // End-of-window gain adjustment for one channel.
  function automatic logic [GAIN_W-1:0] step_gain(
    input logic [GAIN_W-1:0] g,
    input logic [MAG_W-1:0]  peak,
    input logic [MAG_W-1:0]  lo,
    input logic [MAG_W-1:0]  hi,
    input logic [GAIN_W-1:0] step,
    input logic [GAIN_W-1:0] mx
  );
    logic [GAIN_W:0]   sum;
    logic [GAIN_W-1:0] r;
    sum = {1'b0, g} + {1'b0, step};
    if (peak < lo) begin
      r = (sum > {1'b0, mx}) ? mx : sum[GAIN_W-1:0];
    end else if (peak > hi) begin
      r = (g > step) ? g - step : '0;
    end else begin
      r = g;
    end
    return (r > mx) ? mx : r;
  endfunction

  function automatic result_t make_result(
    input logic [CH_W-1:0]   ch,
    input logic [GAIN_W-1:0] g,
    input logic              last
  );
    result_t r;
    r.channel     = ch;
    r.gain_tenths = g;
    r.dac_word    = {(ch[0] ? DAC_CMD_ODD : DAC_CMD_EVEN), vctl_code(g)};
    r.chip_select = ch[1];
    r.last        = last;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/peak_agc_gain_stepper_core.sv @@
// Four-channel peak-detect automatic gain control, top level.
//
// Usage:
//   item channel   - one beat per ADC frame (op = 0) or direct gain set (op = 1).
//                    A beat is taken at a rising edge with item_valid high and
//                    item_stall low.
//   result channel - one beat per reported channel gain with its DAC command.
//                    The last beat of an item's run has last set.
//   APB port       - low/high threshold, gain step and max gain at byte
//                    addresses 0, 4, 8, 12; write only while the block is idle.
// Throughput: one item per cycle. A direct set gives one result beat, the
//   frame that closes a window gives four (channels 0 to 3); while these
//   are queued the item side stalls.
// Path: an accepted item's gains go to the pending group, then beat by beat to the result register.
// Reset: gains return to 210, peaks clear, the window closes, thresholds and
//   limits take their reset values, no result beat is pending.
// Receiver stall: the result register holds its beat; the queued group
//   holds, and once a group cannot drain the item side stalls too.
`default_nettype none

module peak_agc_gain_stepper_core (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   item_valid,
  output logic                  item_stall,
  input  wire pags_pkg::item_t  item,
  output logic                  result_valid,
  input  wire                   result_stall,
  output pags_pkg::result_t     result,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [3:0]            paddr,
  input  wire  [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // Configuration registers.
  logic [pags_pkg::MAG_W-1:0]  low_threshold;
  logic [pags_pkg::MAG_W-1:0]  high_threshold;
  logic [pags_pkg::GAIN_W-1:0] gain_step;
  logic [pags_pkg::GAIN_W-1:0] max_gain;

  // Window and gain state.
  logic [pags_pkg::MAG_W-1:0]  peak_mag      [pags_pkg::CHANNELS];
  logic [pags_pkg::MAG_W-1:0]  peak_mag_next [pags_pkg::CHANNELS];
  logic [pags_pkg::GAIN_W-1:0] chan_gain      [pags_pkg::CHANNELS];
  logic [pags_pkg::GAIN_W-1:0] chan_gain_next [pags_pkg::CHANNELS];
  logic [pags_pkg::CNT_W-1:0]  frame_count, frame_count_next;
  logic                        window_open, window_open_next;

  // Pending result group: gains captured at accept, count and next channel.
  logic [pags_pkg::GAIN_W-1:0] gain_snap      [pags_pkg::CHANNELS];
  logic [pags_pkg::GAIN_W-1:0] gain_snap_next [pags_pkg::CHANNELS];
  logic [pags_pkg::PEND_W-1:0] pend, pend_next;
  logic [pags_pkg::CH_W-1:0]   pend_ch, pend_ch_next;

  logic                        result_valid_next;
  pags_pkg::result_t           result_next;

  logic                        accept;
  logic                        drain;
  logic                        win_start;
  logic                        win_active;
  logic                        win_end;
  logic [pags_pkg::CNT_W-1:0]  cnt_base;
  logic [pags_pkg::MAG_W-1:0]  sample_mag [pags_pkg::CHANNELS];
  logic [pags_pkg::MAG_W-1:0]  peak_upd   [pags_pkg::CHANNELS];
  logic [pags_pkg::GAIN_W-1:0] set_gain;
  logic [pags_pkg::CH_W-1:0]   set_ch;
  logic                        cfg_write;

  // ---------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------
  // Move the next pending beat into the result register whenever it is free.
  assign drain  = (pend != '0) && (!result_valid || !result_stall);
  // Take a new item only when the pending group is empty or empties this cycle.
  assign item_stall = (pend > pags_pkg::PEND_W'(1)) ||
                      ((pend == pags_pkg::PEND_W'(1)) && !drain);
  assign accept = item_valid && !item_stall;

  // ---------------------------------------------------------------------
  // Frame path: magnitude, peak hold, window count
  // ---------------------------------------------------------------------
  assign win_start  = item.burst_start;
  assign win_active = win_start || window_open;
  assign cnt_base   = win_start ? '0 : frame_count;
  assign win_end    = (cnt_base == pags_pkg::CNT_W'(pags_pkg::WINDOW - 1));

  assign sample_mag[0] = pags_pkg::abs_sat(item.sample_ch0);
  assign sample_mag[1] = pags_pkg::abs_sat(item.sample_ch1);
  assign sample_mag[2] = pags_pkg::abs_sat(item.sample_ch2);
  assign sample_mag[3] = pags_pkg::abs_sat(item.sample_ch3);

  always_comb begin
    for (int c = 0; c < pags_pkg::CHANNELS; c++) begin
      // A burst start clears the held peak before this frame is folded in.
      if (win_start) begin
        peak_upd[c] = sample_mag[c];
      end else begin
        peak_upd[c] = (sample_mag[c] > peak_mag[c]) ? sample_mag[c] : peak_mag[c];
      end
    end
  end

  // Direct set: clamp the request to the maximum gain.
  assign set_ch   = item.target_channel[pags_pkg::CH_W-1:0];
  assign set_gain = (item.requested_gain > {7'd0, max_gain}) ? max_gain :
                    item.requested_gain[pags_pkg::GAIN_W-1:0];

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    peak_mag_next     = peak_mag;
    chan_gain_next    = chan_gain;
    gain_snap_next    = gain_snap;
    frame_count_next  = frame_count;
    window_open_next  = window_open;
    pend_next         = pend;
    pend_ch_next      = pend_ch;
    result_valid_next = result_valid;
    result_next       = result;

    // Output side: advance the pending group by one beat, or drop a taken beat.
    if (drain) begin
      result_valid_next = 1'b1;
      result_next       = pags_pkg::make_result(pend_ch, gain_snap[pend_ch],
                                                pend == pags_pkg::PEND_W'(1));
      pend_next         = pend - pags_pkg::PEND_W'(1);
      pend_ch_next      = pend_ch + pags_pkg::CH_W'(1);
    end else if (!result_stall) begin
      result_valid_next = 1'b0;
    end

    // Input side: a taken item only ever lands on an empty pending group.
    if (accept) begin
      if (item.op == pags_pkg::OP_SET) begin
        // Direct set to channels 4..7 is dropped without a result.
        if (!item.target_channel[2]) begin
          chan_gain_next[set_ch] = set_gain;
          gain_snap_next[set_ch] = set_gain;
          pend_next              = pags_pkg::PEND_W'(1);
          pend_ch_next           = set_ch;
        end
      end else if (win_active) begin
        peak_mag_next = peak_upd;
        if (win_end) begin
          // Close the window: step every gain and queue all channels.
          for (int c = 0; c < pags_pkg::CHANNELS; c++) begin
            chan_gain_next[c] = pags_pkg::step_gain(chan_gain[c], peak_upd[c],
                                                    low_threshold, high_threshold,
                                                    gain_step, max_gain);
            gain_snap_next[c] = chan_gain_next[c];
          end
          frame_count_next = '0;
          window_open_next = 1'b0;
          pend_next        = pags_pkg::PEND_W'(pags_pkg::CHANNELS);
          pend_ch_next     = '0;
        end else begin
          frame_count_next = cnt_base + pags_pkg::CNT_W'(1);
          window_open_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < pags_pkg::CHANNELS; c++) begin
        peak_mag[c]  <= '0;
        chan_gain[c] <= pags_pkg::GAIN_RESET;
      end
      frame_count  <= '0;
      window_open  <= 1'b0;
      pend         <= '0;
      pend_ch      <= '0;
      result_valid <= 1'b0;
    end else begin
      peak_mag     <= peak_mag_next;
      chan_gain    <= chan_gain_next;
      frame_count  <= frame_count_next;
      window_open  <= window_open_next;
      pend         <= pend_next;
      pend_ch      <= pend_ch_next;
      result_valid <= result_valid_next;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    gain_snap <= gain_snap_next;
    result    <= result_next;
  end

  // ---------------------------------------------------------------------
  // APB configuration port
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold  <= pags_pkg::LOW_THR_RESET;
      high_threshold <= pags_pkg::HIGH_THR_RESET;
      gain_step      <= pags_pkg::STEP_RESET;
      max_gain       <= pags_pkg::MAX_GAIN_RESET;
    end else if (cfg_write) begin
      unique case (pags_pkg::reg_idx_t'(paddr[3:2]))
        pags_pkg::REG_LOW_THR:  low_threshold  <= pwdata[pags_pkg::MAG_W-1:0];
        pags_pkg::REG_HIGH_THR: high_threshold <= pwdata[pags_pkg::MAG_W-1:0];
        pags_pkg::REG_STEP:     gain_step      <= pwdata[pags_pkg::GAIN_W-1:0];
        pags_pkg::REG_MAX_GAIN: max_gain       <= pwdata[pags_pkg::GAIN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (pags_pkg::reg_idx_t'(paddr[3:2]))
      pags_pkg::REG_LOW_THR:  prdata = {17'd0, low_threshold};
      pags_pkg::REG_HIGH_THR: prdata = {17'd0, high_threshold};
      pags_pkg::REG_STEP:     prdata = {23'd0, gain_step};
      pags_pkg::REG_MAX_GAIN: prdata = {23'd0, max_gain};
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/pags_chk.sv @@
// Port-level checker for the peak AGC gain stepper, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module pags_chk (
  input wire                    clk,
  input wire                    rst,
  input wire                    result_valid,
  input wire                    result_stall,
  input wire pags_pkg::result_t result
);

  `ASSERT_SYNC(a_result_hold, clk, rst,
               result_valid && result_stall |=> result_valid && $stable(result),
               "stalled result beat changed")
  `ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !result_valid,
                 "result beat valid right after reset")
  `ASSERT_SYNC(a_cmd_prefix, clk, rst,
               result_valid |-> (result.chip_select == result.channel[1]) &&
               (result.dac_word[15:12] == (result.channel[0] ? pags_pkg::DAC_CMD_ODD :
                                           pags_pkg::DAC_CMD_EVEN)),
               "chip select or DAC command does not match channel")
  `ASSERT_SYNC(a_low_gain_code, clk, rst,
               result_valid && (result.gain_tenths <= 9'd48) |->
               result.dac_word[11:0] == pags_pkg::DAC_CODE_HI,
               "wrong DAC code for low gain")
  `ASSERT_SYNC(a_last_marks, clk, rst,
               result_valid && !result.last |-> result.channel != 2'd3,
               "non-final beat reports channel 3")

endmodule

bind peak_agc_gain_stepper_core pags_chk u_pags_chk (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for the four-channel peak AGC gain stepper: random frames and gain sets.
`timescale 1ns / 1ps

import pags_pkg::*;

// Tracks the gain stepper state, predicts the result beats of each accepted item
// and checks the beats that come back in order.
class gain_tracker;
  result_t     due_results[$];
  int unsigned thr_low, thr_high, step_size, gain_cap;
  int unsigned peak[CHANNELS];
  int unsigned gain[CHANNELS];
  int unsigned frames_in;
  bit          window_live;
  int          errors, beats_seen, windows_closed, items_used, beats_due_total;

  function new();
    thr_low   = LOW_THR_RESET;
    thr_high  = HIGH_THR_RESET;
    step_size = STEP_RESET;
    gain_cap  = MAX_GAIN_RESET;
    foreach (gain[c]) begin
      gain[c] = GAIN_RESET;
      peak[c] = 0;
    end
    frames_in   = 0;
    window_live = 1'b0;
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function void set_reg(reg_idx_t r, int unsigned v);
    case (r)
      REG_LOW_THR:  thr_low   = v;
      REG_HIGH_THR: thr_high  = v;
      REG_STEP:     step_size = v;
      REG_MAX_GAIN: gain_cap  = v;
    endcase
  endfunction

  function int unsigned reg_value(reg_idx_t r);
    case (r)
      REG_LOW_THR:  return thr_low;
      REG_HIGH_THR: return thr_high;
      REG_STEP:     return step_size;
      default:      return gain_cap;
    endcase
  endfunction

  // Control voltage in tenths of a volt, clamped, then scaled to a 12-bit code.
  function logic [15:0] dac_word_for(int unsigned ch, int unsigned g);
    int          vt;
    int unsigned code;
    vt = 2 * (54 - int'(g));
    if (vt > 12) vt = 12;
    if (vt < 1) vt = 1;
    code = (vt * 4095) / 33;
    return {((ch % 2) != 0) ? DAC_CMD_ODD : DAC_CMD_EVEN, 12'(code)};
  endfunction

  function void queue_result(int unsigned ch, bit last);
    result_t r;
    r.channel     = 2'(ch);
    r.gain_tenths = 9'(gain[ch]);
    r.dac_word    = dac_word_for(ch, gain[ch]);
    r.chip_select = (ch >= 2);
    r.last        = last;
    due_results.push_back(r);
    beats_due_total++;
  endfunction

  // Returns 1 when the item had any effect on the block.
  function bit take_item(item_t it);
    logic signed [15:0] s[CHANNELS];
    int                 mag;
    int unsigned        g;
    s[0] = it.sample_ch0;
    s[1] = it.sample_ch1;
    s[2] = it.sample_ch2;
    s[3] = it.sample_ch3;
    if (it.op == OP_SET) begin
      if (it.target_channel >= CHANNELS) return 1'b0;
      g = it.requested_gain;
      if (g > gain_cap) g = gain_cap;
      gain[it.target_channel] = g;
      queue_result(it.target_channel, 1'b1);
      items_used++;
      return 1'b1;
    end
    if (it.burst_start) begin
      foreach (peak[c]) peak[c] = 0;
      frames_in   = 0;
      window_live = 1'b1;
    end
    if (!window_live) return 1'b0;
    foreach (peak[c]) begin
      mag = s[c];
      if (mag < 0) mag = -mag;
      if (mag > 32767) mag = 32767;   // most negative code saturates
      if (mag > peak[c]) peak[c] = mag;
    end
    frames_in++;
    items_used++;
    if (frames_in < WINDOW) return 1'b1;
    for (int c = 0; c < CHANNELS; c++) begin
      g = gain[c];
      if (peak[c] < thr_low) begin
        g = g + step_size;
        if (g > gain_cap) g = gain_cap;
      end else if (peak[c] > thr_high) begin
        g = (g > step_size) ? g - step_size : 0;
      end
      if (g > gain_cap) g = gain_cap;
      gain[c] = g;
      queue_result(c, c == CHANNELS - 1);
    end
    window_live = 1'b0;
    frames_in   = 0;
    windows_closed++;
    return 1'b1;
  endfunction

  function void check_beat(result_t got);
    result_t want;
    beats_seen++;
    if (due_results.size() == 0) begin
      flag($sformatf("result beat %0d arrived with nothing expected: ch=%0d gain=%0d",
                     beats_seen, got.channel, got.gain_tenths));
      return;
    end
    want = due_results.pop_front();
    if (got.channel !== want.channel || got.gain_tenths !== want.gain_tenths ||
        got.dac_word !== want.dac_word || got.chip_select !== want.chip_select ||
        got.last !== want.last) begin
      flag($sformatf({"result beat %0d mismatch: expected ch=%0d gain=%0d dac=%h cs=%b ",
                      "last=%b, got ch=%0d gain=%0d dac=%h cs=%b last=%b"}, beats_seen,
                     want.channel, want.gain_tenths, want.dac_word, want.chip_select,
                     want.last, got.channel, got.gain_tenths, got.dac_word,
                     got.chip_select, got.last));
    end
  endfunction

  function void close_out();
    if (due_results.size() != 0)
      flag($sformatf("%0d result beats never arrived", due_results.size()));
  endfunction
endclass

module tb_top;

  localparam int HOLD_CYCLES     = 150;     // long receiver hold-off
  localparam int SETTLE_CYCLES   = 10;      // settling margin after the last result beat
  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 55;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  item_t       item         = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [3:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        hold_go      = 1'b0;
  int          hold_left;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          cycle_count  = 0;
  int          settings_run = 0;
  gain_tracker tracker;

  peak_agc_gain_stepper_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk = ~clk;

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: check each accepted beat, then pick the stall for the next cycle.
  // A pulse on hold_go holds the stall high for a hold-off counted down here in hold_left.
  always @(posedge clk) begin
    if (rst) begin
      hold_left    <= 0;
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) tracker.check_beat(result);
      if (hold_go) begin
        hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      result_stall <= hold_go || (hold_left > 1) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one beat and hold it until accepted. Valid is left high on return so
  // back-to-back beats need no drop; callers that stop sending use wait_idle.
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    void'(tracker.take_item(it));
  endtask

  // Drop valid, wait out every pending result beat, then let the pipeline settle.
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t r, input int unsigned v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(r, v);
    @(posedge clk);
  endtask

  // Read back all four registers and compare with what was last written.
  task automatic check_regs();
    reg_idx_t    r;
    logic [31:0] got;
    for (int i = 0; i < 4; i++) begin
      r       = reg_idx_t'(i);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {r, 2'b00};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      got     = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
      if (got !== 32'(tracker.reg_value(r)))
        tracker.flag($sformatf("register %s read %0d, expected %0d", r.name(), got,
                               tracker.reg_value(r)));
    end
  endtask

  // Sample drawn from an amplitude class: quiet, mid, full scale, or quiet with
  // the occasional most negative code.
  function automatic logic [15:0] pick_sample(int cls);
    int v;
    case (cls)
      0:       v = $urandom_range(2000);
      1:       v = $urandom_range(20000);
      2:       return 16'($urandom_range(16'hFFFF));
      default: begin
        if ($urandom_range(15) == 0) return 16'h8000;
        v = $urandom_range(2000);
      end
    endcase
    if ($urandom_range(1) == 1) v = -v;
    return 16'(v);
  endfunction

  function automatic item_t make_frame(logic bs, int cls[CHANNELS]);
    item_t it;
    it             = '0;
    it.op          = OP_FRAME;
    it.burst_start = bs;
    it.sample_ch0  = pick_sample(cls[0]);
    it.sample_ch1  = pick_sample(cls[1]);
    it.sample_ch2  = pick_sample(cls[2]);
    it.sample_ch3  = pick_sample(cls[3]);
    // unused fields still carry noise
    it.target_channel = 3'($urandom_range(7));
    it.requested_gain = 16'($urandom_range(16'hFFFF));
    return it;
  endfunction

  function automatic item_t make_set(int ch, int unsigned g);
    item_t it;
    it                = '0;
    it.op             = OP_SET;
    it.burst_start    = 1'($urandom_range(1));
    it.sample_ch0     = 16'($urandom_range(16'hFFFF));
    it.sample_ch2     = 16'($urandom_range(16'hFFFF));
    it.target_channel = 3'(ch);
    it.requested_gain = 16'(g);
    return it;
  endfunction

  function automatic item_t random_set();
    int unsigned g;
    case ($urandom_range(3))
      0:       g = $urandom_range(600);
      1:       g = $urandom_range(16'hFFFF);
      2:       g = $urandom_range(44, 56);
      default: g = $urandom_range(480);
    endcase
    return make_set($urandom_range(7), g);
  endfunction

  // One burst window: opening frame plus the rest, each channel in its own
  // amplitude class. Now and then cut it short or restart it part way, and
  // slip a gain set in between frames.
  task automatic run_window();
    int cls[CHANNELS];
    int len;
    int restart_at;
    foreach (cls[c]) cls[c] = $urandom_range(3);
    len        = ($urandom_range(9) == 0) ? $urandom_range(1, WINDOW - 2) : WINDOW - 1;
    restart_at = ($urandom_range(9) == 0) ? $urandom_range(1, len) : -1;
    send_item(make_frame(1'b1, cls));
    for (int k = 1; k <= len; k++) begin
      if ($urandom_range(99) < 3) send_item(random_set());
      send_item(make_frame(k == restart_at, cls));
    end
  endtask

  initial begin
    int          base;
    int          pick;
    int unsigned lo, hi, stp, mx;
    int          dir_ch[16]   = '{0, 1, 2, 3, 0, 1, 2, 3, 0, 1, 2, 3, 4, 7, 5, 6};
    int unsigned dir_gain[16] = '{65535, 0, 49, 50, 51, 52, 53, 54, 48, 481,
                                  32768, 32767, 100, 200, 65535, 0};
    int          noise_cls[CHANNELS] = '{2, 2, 2, 2};
    int          quiet_cls[CHANNELS] = '{0, 0, 0, 0};
    item_t       it;

    tracker = new();
    send_idle_pct = 14;
    recv_idle_pct = 48;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers must read back their reset values.
    check_regs();

    // Directed part, reset settings. A frame with no open window is dropped.
    it            = make_frame(1'b0, noise_cls);
    it.sample_ch0 = 16'sh8000;
    it.sample_ch1 = 16'sh7FFF;
    it.sample_ch2 = 16'sh0000;
    it.sample_ch3 = 16'shFFFF;
    send_item(it);
    // Gain sets: clamp to max, zero, each DAC code step around 48..54, and the
    // missing channels 4 to 7, which give no beat.
    for (int i = 0; i < 16; i++) send_item(make_set(dir_ch[i], dir_gain[i]));
    // Open a window on full-scale extremes, then restart it straight away.
    it            = make_frame(1'b1, quiet_cls);
    it.sample_ch0 = 16'sh8000;
    it.sample_ch1 = 16'sh7FFF;
    it.sample_ch2 = 16'sh8001;
    send_item(it);
    send_item(make_frame(1'b1, quiet_cls));
    send_item(make_set(2, 210));

    for (int phase = 1; phase <= 6; phase++) begin
      wait_idle();
      // Receiver idles first, then sender, then neither.
      if (phase <= 2) begin
        send_idle_pct = 14;
        recv_idle_pct = 48;
      end else if (phase <= 4) begin
        send_idle_pct = 48;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        1: begin lo = 1000;  hi = 20000; stp = 45;  mx = 300; end
        2: begin lo = 0;     hi = 32767; stp = 480; mx = 480; end
        3: begin lo = 32767; hi = 0;     stp = 480; mx = 480; end   // crossed: rise wins
        4: begin lo = 20000; hi = 10000; stp = 0;   mx = 0;   end
        5: begin lo = 8000;  hi = 16000; stp = 1;   mx = 55;  end
        default: begin
          lo  = $urandom_range(32767);
          hi  = $urandom_range(32767);
          stp = $urandom_range(480);
          mx  = $urandom_range(480);
        end
      endcase
      apb_write(REG_LOW_THR, lo);
      apb_write(REG_HIGH_THR, hi);
      apb_write(REG_STEP, stp);
      apb_write(REG_MAX_GAIN, mx);
      check_regs();
      settings_run++;

      if (phase == 5) begin
        // Hold the result side off while gain sets keep coming, so the output
        // queue fills and the item side stalls; then drain completely.
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        for (int i = 0; i < 16; i++) send_item(make_set(i % CHANNELS, $urandom_range(600)));
        wait_idle();
      end

      base = tracker.items_used;
      while (tracker.items_used - base < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          run_window();
        end else if (pick < 80) begin
          repeat ($urandom_range(1, 6)) send_item(random_set());
        end else begin
          repeat ($urandom_range(1, 5)) send_item(make_frame(1'b0, noise_cls));
        end
      end
    end

    wait_idle();
    tracker.close_out();
    $display("Covered %0d effective items, %0d result beats, %0d closed windows,",
             tracker.items_used, tracker.beats_seen, tracker.windows_closed);
    $display("  %0d register settings beyond reset, with long output hold-off and full drain.",
             settings_run);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
